/* design/sps_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the serial port register model
// no dependencies

package sps_pkg;

  // item codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TX    = 2'd3;

  // register selects, SADEN and SADDR fall to the default arm
  localparam logic [2:0] SEL_SCON = 3'd0;
  localparam logic [2:0] SEL_SBUF = 3'd1;
  localparam logic [2:0] SEL_PCON = 3'd2;

  // scon bit positions
  localparam int unsigned POS_RI  = 0;
  localparam int unsigned POS_TI  = 1;
  localparam int unsigned POS_RB8 = 2;
  localparam int unsigned POS_TB8 = 3;
  localparam int unsigned POS_REN = 4;
  localparam int unsigned POS_SM1 = 6;
  localparam int unsigned POS_SM0 = 7;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] reg_sel;
    logic [7:0] wdata;
    logic [8:0] rx_char;
  } sps_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       tx_valid;
    logic [8:0] tx_char;
    logic       irq;
    logic       rx_enabled;
    logic       tx_busy;
    logic       nine_bit_mode;
  } sps_out_t;

endpackage

/* design/serial_port_sfr_model.sv */
`timescale 1ns / 1ps
// Serial port register model (SCON, SBUF, PCON). Each beat is a register read,
// a register write, a received character or a transmit request, and gives one
// result beat. One beat is accepted per cycle while the result side takes its
// results; a beat waits in the input register, then the register update and
// result are formed combinationally into the result register, and the state
// read-modify-write completes in that same step. Back-pressure on the result
// side stalls the input register only once the result register is full.
// depends on sps_pkg, sps_in_stage, sps_sfr

module serial_port_sfr_model
  import sps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sps_out_t out_data
);

  logic     stg_valid;
  sps_in_t  stg_data;
  logic     fire;
  sps_out_t res;
  logic     out_valid_r, out_valid_nxt;
  sps_out_t out_data_r;

  assign fire = stg_valid && (!out_valid_r || out_ready);

  sps_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (fire),
    .stg_valid (stg_valid),
    .stg_data  (stg_data)
  );

  sps_sfr u_sfr (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (stg_data),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/sps_in_stage.sv */
`timescale 1ns / 1ps
// input register: holds one accepted beat until the register stage takes it
// depends on sps_pkg

module sps_in_stage
  import sps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sps_in_t in_data,
  input  logic    take,
  output logic    stg_valid,
  output sps_in_t stg_data
);

  logic    vld_r;
  logic    vld_nxt;
  sps_in_t data_r;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign stg_valid = vld_r;
  assign stg_data  = data_r;

endmodule

/* design/sps_sfr.sv */
`timescale 1ns / 1ps
// special function registers and the per-beat update of scon, sbuf and pcon
// depends on sps_pkg

module sps_sfr
  import sps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  sps_in_t  item,
  output sps_out_t res
);

  logic [7:0] scon_r, scon_nxt;
  logic [7:0] tbuf_r, tbuf_nxt;
  logic [7:0] rbuf_r, rbuf_nxt;
  logic [7:0] pcon_r, pcon_nxt;
  logic       nine_r, nine_nxt;
  logic       armed_r, armed_nxt;
  logic       rx_on_r, rx_on_nxt;
  logic       known_r, known_nxt;
  logic [7:0] scon_wr;
  logic       mode_chg;

  // ri and ti can only be cleared by a write
  always_comb begin
    scon_wr         = item.wdata;
    scon_wr[POS_RI] = item.wdata[POS_RI] & scon_r[POS_RI];
    scon_wr[POS_TI] = item.wdata[POS_TI] & scon_r[POS_TI];
  end

  assign mode_chg = (scon_wr[POS_SM0] ^ scon_r[POS_SM0]) |
                    (scon_wr[POS_SM1] ^ scon_r[POS_SM1]) | !known_r;

  always_comb begin
    scon_nxt  = scon_r;
    tbuf_nxt  = tbuf_r;
    rbuf_nxt  = rbuf_r;
    pcon_nxt  = pcon_r;
    nine_nxt  = nine_r;
    armed_nxt = armed_r;
    rx_on_nxt = rx_on_r;
    known_nxt = known_r;
    res       = '0;
    unique case (item.op)
      OP_READ: begin
        unique case (item.reg_sel)
          SEL_SCON: res.rdata = scon_r;
          SEL_SBUF: res.rdata = rbuf_r;
          SEL_PCON: res.rdata = pcon_r;
          default:  res.rdata = 8'h00;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_sel)
          SEL_SCON: begin
            scon_nxt  = scon_wr;
            rx_on_nxt = scon_wr[POS_REN];
            if (mode_chg) begin
              nine_nxt  = scon_wr[POS_SM0];
              known_nxt = 1'b1;
            end
          end
          SEL_SBUF: begin
            tbuf_nxt  = item.wdata;
            armed_nxt = 1'b1;
          end
          SEL_PCON: pcon_nxt = item.wdata;
          default: ;
        endcase
      end
      OP_RX: begin
        rbuf_nxt          = item.rx_char[7:0];
        scon_nxt[POS_RB8] = item.rx_char[8];
        scon_nxt[POS_RI]  = 1'b1;
      end
      OP_TX: begin
        if (armed_r) begin
          res.tx_valid     = 1'b1;
          res.tx_char      = {nine_r & scon_r[POS_TB8], tbuf_r};
          armed_nxt        = 1'b0;
          scon_nxt[POS_TI] = 1'b1;
        end
      end
    endcase
    res.irq           = scon_nxt[POS_RI] | scon_nxt[POS_TI];
    res.rx_enabled    = rx_on_nxt;
    res.tx_busy       = armed_nxt;
    res.nine_bit_mode = nine_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scon_r  <= '0;
      tbuf_r  <= '0;
      rbuf_r  <= '0;
      pcon_r  <= '0;
      nine_r  <= 1'b0;
      armed_r <= 1'b0;
      rx_on_r <= 1'b0;
      known_r <= 1'b0;
    end else if (fire) begin
      scon_r  <= scon_nxt;
      tbuf_r  <= tbuf_nxt;
      rbuf_r  <= rbuf_nxt;
      pcon_r  <= pcon_nxt;
      nine_r  <= nine_nxt;
      armed_r <= armed_nxt;
      rx_on_r <= rx_on_nxt;
      known_r <= known_nxt;
    end
  end

endmodule

/* design/sps_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the serial port register model, bound to the top level
// depends on sps_pkg and serial_port_sfr_model

module sps_checker
  import sps_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input sps_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input sps_out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no character means an all-zero character
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_char == 9'd0)
    else $error("tx_char set without tx_valid");

  // a handed-out character disarms the transmitter and raises ti
  a_tx_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |-> !out_data.tx_busy && out_data.irq)
    else $error("transmit left busy or without interrupt");

  // ninth bit only in nine-bit mode
  a_tx_ninth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid && !out_data.nine_bit_mode |-> !out_data.tx_char[8])
    else $error("ninth bit sent in eight-bit mode");

endmodule

bind serial_port_sfr_model sps_checker u_sps_checker (.*);
